FILE: hw/rtl/svptw_pkg.sv
// ---------------------------------------------------------------------------
// svptw_pkg - shared types and constants of the Sv39 page-table walker
// Command and status bundles between controller and datapath, result kinds
// and status codes.
// ---------------------------------------------------------------------------
`default_nettype none

package svptw_pkg;

  // Default store size in 64-bit words (whole 512-word table pages)
  localparam int unsigned DEF_STORE_WORDS = 4096;
  localparam int unsigned TABLE_ENTRIES   = 512;
  localparam int unsigned IDX_W           = 9;

  // Field widths of the item and result
  localparam int unsigned WIDX_W  = 12;
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned PPN_W   = 44;
  localparam int unsigned VA_W    = 39;
  localparam int unsigned NPPN_W  = 54;   // entry bits 63..10
  localparam int unsigned PA_W    = 56;
  localparam int unsigned PROT_W  = 10;

  localparam logic [PROT_W-1:0] COW_MASK = 10'h100;

  // Item kind carried on the input side
  localparam logic ACT_WRITE     = 1'b0;
  localparam logic ACT_TRANSLATE = 1'b1;

  // Walk levels
  localparam logic [1:0] LVL_TOP  = 2'd0;
  localparam logic [1:0] LVL_LEAF = 2'd2;

  typedef enum logic [1:0] {
    STATUS_DONE       = 2'd0,
    STATUS_NOT_MAPPED = 2'd1,
    STATUS_OUT_RANGE  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    RES_ZERO       = 2'd0,
    RES_OUT_RANGE  = 2'd1,
    RES_NOT_MAPPED = 2'd2,
    RES_LEAF       = 2'd3
  } res_kind_e;

  // Controller to datapath
  typedef struct packed {
    logic      take;       // capture root page and virtual address
    logic      wr_en;      // table word write from the input item
    logic      rd_en;      // issue a table read
    logic      chk_entry;  // page under check comes from the last entry read
    logic [1:0] rd_level;  // level whose index selects the word
    logic      res_load;   // capture the outcome
    res_kind_e res_kind;
    logic      out_load;   // move the outcome into the output register
  } svptw_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic page_ok;      // page under check lies inside the store
    logic entry_valid;  // valid bit of the last entry read
    logic out_free;     // output register can take a result this cycle
  } svptw_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/svptw_ctrl.sv
// ---------------------------------------------------------------------------
// svptw_ctrl - walk controller
// Sequences table writes, the three-level walk and the hand-over of each
// result to the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module svptw_ctrl
  import svptw_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_action_i,
  output logic            in_ready_o,
  input  wire svptw_sts_t sts_i,
  output svptw_cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_EVAL,
    S_RESP
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] lvl_q, lvl_d;
  logic       in_xfer;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    lvl_d   = lvl_q;
    cmd_o   = '{default: '0, res_kind: RES_ZERO};
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_action_i == ACT_WRITE) begin
            cmd_o.wr_en    = 1'b1;
            cmd_o.res_load = 1'b1;
            cmd_o.res_kind = RES_ZERO;
            state_d        = S_RESP;
          end else begin
            cmd_o.take = 1'b1;
            lvl_d      = LVL_TOP;
            state_d    = S_ISSUE;
          end
        end
      end
      S_ISSUE: begin
        // root table page checked and top-level entry read
        cmd_o.rd_level = LVL_TOP;
        if (!sts_i.page_ok) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_kind = RES_OUT_RANGE;
          state_d        = S_RESP;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_EVAL;
        end
      end
      S_EVAL: begin
        // entry of level lvl_q is in the read register
        cmd_o.chk_entry = 1'b1;
        cmd_o.rd_level  = lvl_q + 2'd1;
        priority if (!sts_i.entry_valid) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_kind = RES_NOT_MAPPED;
          state_d        = S_RESP;
        end else if (lvl_q == LVL_LEAF) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_kind = RES_LEAF;
          state_d        = S_RESP;
        end else if (!sts_i.page_ok) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_kind = RES_OUT_RANGE;
          state_d        = S_RESP;
        end else begin
          cmd_o.rd_en = 1'b1;
          lvl_d       = lvl_q + 2'd1;
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lvl_q   <= LVL_TOP;
    end else begin
      state_q <= state_d;
      lvl_q   <= lvl_d;
    end
  end

  // The walk never goes past the leaf level
  assert property (@(posedge clk_i) disable iff (!rst_ni) lvl_q != 2'd3)
    else $error("walk level beyond leaf");

  // Every read is evaluated in the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_o.rd_en |=> state_q == S_EVAL)
    else $error("table read not followed by evaluation");

  // A result waits while the output register is occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == S_RESP && !sts_i.out_free) |=> state_q == S_RESP)
    else $error("result dropped while output stalled");

endmodule

`default_nettype wire

FILE: hw/rtl/svptw_dpath.sv
// ---------------------------------------------------------------------------
// svptw_dpath - walk datapath
// Table store, page range check, entry read register, outcome and output
// registers.
// ---------------------------------------------------------------------------
`default_nettype none

module svptw_dpath
  import svptw_pkg::*;
#(
  parameter int unsigned STORE_WORDS = DEF_STORE_WORDS
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [PPN_W-1:0]  cfg_wdata_i,
  input  wire logic [WIDX_W-1:0] word_index_i,
  input  wire logic [WORD_W-1:0] word_value_i,
  input  wire logic [PPN_W-1:0]  root_page_i,
  input  wire logic [VA_W-1:0]   virt_addr_i,
  input  wire svptw_cmd_t        cmd_i,
  output svptw_sts_t             sts_o,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output logic [1:0]             status_o,
  output logic                   hit_o,
  output logic [PA_W-1:0]        phys_addr_o,
  output logic [PROT_W-1:0]      prot_bits_o,
  output logic                   cow_flag_o
);

  localparam int unsigned ADDR_W = $clog2(STORE_WORDS);
  localparam int unsigned NPAGES = STORE_WORDS / TABLE_ENTRIES;

  logic [PPN_W-1:0]  base_q;
  logic [PPN_W-1:0]  root_q;
  logic [VA_W-1:0]   va_q;
  logic [WORD_W-1:0] table_mem_q [STORE_WORDS];
  logic [WORD_W-1:0] rdata_q;

  logic [NPPN_W-1:0] chk_page, page_off;
  logic [IDX_W-1:0]  idx;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [31:0]       widx_ext;
  logic              wr_ok;

  logic [1:0]        res_status_q;
  logic              res_hit_q, res_cow_q;
  logic [PA_W-1:0]   res_pa_q;
  logic [PROT_W-1:0] res_prot_q;
  logic              out_valid_q;

  // Base page register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (cfg_we_i) begin
      base_q <= cfg_wdata_i;
    end
  end

  // Walk operands
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      root_q <= root_page_i;
      va_q   <= virt_addr_i;
    end
  end

  // Page range check and word address
  assign chk_page = cmd_i.chk_entry ? rdata_q[WORD_W-1:10] : NPPN_W'(root_q);
  assign page_off = chk_page - NPPN_W'(base_q);

  always_comb begin
    unique case (cmd_i.rd_level)
      2'd0:    idx = va_q[38:30];
      2'd1:    idx = va_q[29:21];
      2'd2:    idx = va_q[20:12];
      default: idx = '0;
    endcase
  end

  assign rd_addr = ADDR_W'({page_off, idx});

  assign widx_ext = 32'(word_index_i);
  assign wr_ok    = widx_ext < 32'(STORE_WORDS);
  assign wr_addr  = widx_ext[ADDR_W-1:0];

  // Table store, one write or one read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && wr_ok) begin
      table_mem_q[wr_addr] <= word_value_i;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= table_mem_q[rd_addr];
    end
  end

  assign sts_o.page_ok     = (chk_page >= NPPN_W'(base_q)) && (page_off < NPPN_W'(NPAGES));
  assign sts_o.entry_valid = rdata_q[0];
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  // Outcome register
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_hit_q  <= 1'b0;
      res_pa_q   <= '0;
      res_prot_q <= '0;
      res_cow_q  <= 1'b0;
      unique case (cmd_i.res_kind)
        RES_ZERO:       res_status_q <= STATUS_DONE;
        RES_OUT_RANGE:  res_status_q <= STATUS_OUT_RANGE;
        RES_NOT_MAPPED: res_status_q <= STATUS_NOT_MAPPED;
        RES_LEAF: begin
          res_status_q <= STATUS_DONE;
          res_hit_q    <= 1'b1;
          res_pa_q     <= PA_W'({rdata_q[WORD_W-1:10], 12'h000});
          res_prot_q   <= rdata_q[PROT_W-1:0] & ~COW_MASK;
          res_cow_q    <= rdata_q[8];
        end
        default:        res_status_q <= STATUS_DONE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_o    <= res_status_q;
      hit_o       <= res_hit_q;
      phys_addr_o <= res_pa_q;
      prot_bits_o <= res_prot_q;
      cow_flag_o  <= res_cow_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // The output register is only loaded when free
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_i.out_load |-> sts_o.out_free)
    else $error("output overwritten while stalled");

  // A hit always reports a completed walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && hit_o) |-> status_o == STATUS_DONE)
    else $error("hit with failing status");

  // A failed walk carries no translation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && status_o != STATUS_DONE) |->
                   (phys_addr_o == '0 && prot_bits_o == '0 && !cow_flag_o && !hit_o))
    else $error("failed walk with translation data");

endmodule

`default_nettype wire

FILE: hw/rtl/sv39_page_table_walker.sv
// ---------------------------------------------------------------------------
// sv39_page_table_walker - Sv39 translation walk over a local table store
// Write items load 64-bit table words; translate items walk up to three levels.
// ---------------------------------------------------------------------------
// Usage:
//   The slave stream takes one item per transfer; s_axis_tuser selects a
//   table word write (0) or a translation (1). Every item yields exactly one
//   transfer on the master stream: status in m_axis_tuser, the translation in
//   m_axis_tdata (all zero for a write or a failed walk).
//   store_base_page is loaded through cfg_we_i/cfg_wdata_i; the user must
//   load it only while idle, as the walker does not enforce this. A translation
//   that stops early finishes sooner than a full walk. One item is in work at
//   a time, so a new item is taken only after the previous result has
//   entered the output register. The walk is bound by its dependent table
//   reads: one entry read per level, each evaluated the cycle after it is
//   read.
//   A result waits in the output register while m_axis_tready is low; the
//   walker holds its next result until that register frees.
//   Reset clears the base page register and all control state; table words
//   are undefined until written.
// ---------------------------------------------------------------------------
`default_nettype none

module sv39_page_table_walker
  import svptw_pkg::*;
#(
  parameter int unsigned STORE_WORDS = DEF_STORE_WORDS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Configuration
  input  wire logic               cfg_we_i,
  input  wire logic [PPN_W-1:0]   cfg_wdata_i,   // store_base_page
  // Item stream
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [159:0]       s_axis_tdata,  // word_index, word_value, root_page,
                                                 // virt_addr, one pad bit
  input  wire logic               s_axis_tuser,  // action
  // Result stream
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [71:0]             m_axis_tdata,  // hit, phys_addr, prot_bits,
                                                 // cow_flag, four pad bits
  output logic [1:0]              m_axis_tuser   // status
);

  svptw_cmd_t        cmd;
  svptw_sts_t        sts;
  logic [1:0]        status;
  logic              hit, cow_flag;
  logic [PA_W-1:0]   phys_addr;
  logic [PROT_W-1:0] prot_bits;

  svptw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_action_i (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  svptw_dpath #(
    .STORE_WORDS (STORE_WORDS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .word_index_i (s_axis_tdata[11:0]),
    .word_value_i (s_axis_tdata[75:12]),
    .root_page_i  (s_axis_tdata[119:76]),
    .virt_addr_i  (s_axis_tdata[158:120]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .status_o     (status),
    .hit_o        (hit),
    .phys_addr_o  (phys_addr),
    .prot_bits_o  (prot_bits),
    .cow_flag_o   (cow_flag)
  );

  // Result packing, lowest field first
  assign m_axis_tdata = {4'h0, cow_flag, prot_bits, phys_addr, hit};
  assign m_axis_tuser = status;

endmodule

`default_nettype wire

FILE: tb/sv/tb_sv39_page_table_walker.sv
// ---------------------------------------------------------------------------
// tb_sv39_page_table_walker - self-checking bench for the Sv39 walker
// Builds page-table paths through table-word writes, then translates through
// them. Every accepted item is run through a local walk predictor and every
// result transfer is checked field by field against the oldest prediction.
// The store base page is reloaded between phases while the walker is idle.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_sv39_page_table_walker;
  import svptw_pkg::*;

  localparam int unsigned NPAGES       = DEF_STORE_WORDS / TABLE_ENTRIES;
  localparam int unsigned PG_W         = $clog2(NPAGES);
  localparam logic [PPN_W-1:0] PPN_MAX = '1;
  localparam int unsigned NUM_PHASES   = 6;
  localparam int unsigned PHASE_ITEMS  = 172;
  localparam int unsigned DRAIN_CYCLES = 12;

  typedef struct {
    logic              act;
    logic [WIDX_W-1:0] widx;
    logic [WORD_W-1:0] wval;
    logic [PPN_W-1:0]  root;
    logic [VA_W-1:0]   va;
  } walk_item_t;

  typedef struct {
    status_e           status;
    logic              hit;
    logic [PA_W-1:0]   pa;
    logic [PROT_W-1:0] prot;
    logic              cow;
  } walk_res_t;

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              cfg_we    = 1'b0;
  logic [PPN_W-1:0]  cfg_wdata = '0;
  logic              s_tvalid  = 1'b0;
  logic [159:0]      s_tdata   = '0;
  logic              s_tuser   = ACT_WRITE;
  logic              m_tready  = 1'b0;
  logic              s_tready;
  logic              m_tvalid;
  logic [71:0]       m_tdata;
  logic [1:0]        m_tuser;

  // Predictor copy of the store and base page
  logic [WORD_W-1:0] pt_store [DEF_STORE_WORDS];
  logic [PPN_W-1:0]  pt_base = '0;

  // Stimulus-side shadow, used to keep walks on written words only
  logic [WORD_W-1:0] plan_mem [DEF_STORE_WORDS];
  bit                plan_written [DEF_STORE_WORDS];
  logic [PPN_W-1:0]  plan_base = '0;
  int unsigned       plan_count = 0;

  walk_item_t        pending_items [$];
  walk_res_t         expected_xlat [$];
  walk_item_t        drv_item;
  walk_res_t         want_res;
  int unsigned       tx_idle_pct = 28;
  int unsigned       rx_idle_pct = 68;
  int                err_cnt = 0;

  sv39_page_table_walker #(
    .STORE_WORDS(DEF_STORE_WORDS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tuser (s_tuser),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),
    .m_axis_tuser (m_tuser)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // Walk predictor: applies a write, or walks up to three levels from the root
  function automatic walk_res_t walk_translate(walk_item_t it);
    walk_res_t         res;
    logic [63:0]       pg;
    logic [63:0]       off;
    logic [63:0]       ent;
    logic [WIDX_W-1:0] w;
    bit                stop;
    res.status = STATUS_DONE;
    res.hit    = 1'b0;
    res.pa     = '0;
    res.prot   = '0;
    res.cow    = 1'b0;
    if (it.act == ACT_WRITE) begin
      pt_store[it.widx] = it.wval;
    end else begin
      pg   = {20'd0, it.root};
      ent  = '0;
      stop = 1'b0;
      for (int lvl = 0; lvl < 3; lvl++) begin
        if (!stop) begin
          off = pg - {20'd0, pt_base};
          if (pg < {20'd0, pt_base} || off >= {32'd0, NPAGES}) begin
            res.status = STATUS_OUT_RANGE;
            stop       = 1'b1;
          end else begin
            w   = {off[PG_W-1:0], it.va[38-9*lvl -: IDX_W]};
            ent = pt_store[w];
            if (!ent[0]) begin
              res.status = STATUS_NOT_MAPPED;
              stop       = 1'b1;
            end else begin
              pg = {10'd0, ent[63:10]};
            end
          end
        end
      end
      if (!stop) begin
        res.hit  = 1'b1;
        res.pa   = {ent[53:10], 12'd0};
        res.prot = ent[PROT_W-1:0] & ~COW_MASK;
        res.cow  = |(ent[PROT_W-1:0] & COW_MASK);
      end
    end
    return res;
  endfunction

  // Item with every field random; callers overwrite what matters
  function automatic walk_item_t rand_fields();
    walk_item_t  it;
    logic [63:0] a;
    logic [63:0] b;
    a       = rnd64();
    b       = rnd64();
    it.act  = ACT_WRITE;
    it.widx = a[11:0];
    it.wval = rnd64();
    it.root = b[43:0];
    it.va   = a[50:12];
    return it;
  endfunction

  function automatic void queue_write(logic [WIDX_W-1:0] idx, logic [WORD_W-1:0] val);
    walk_item_t it;
    it      = rand_fields();
    it.act  = ACT_WRITE;
    it.widx = idx;
    it.wval = val;
    pending_items.push_back(it);
    plan_mem[idx]     = val;
    plan_written[idx] = 1'b1;
    plan_count++;
  endfunction

  // Table entry, mostly valid; a non-leaf entry mostly points back into the store
  function automatic logic [63:0] make_entry(bit leaf);
    logic [63:0] v;
    logic [53:0] pg;
    logic [31:0] k;
    int unsigned r;
    v  = rnd64();
    r  = $urandom_range(0, 99);
    pg = {10'd0, plan_base};
    k  = $urandom_range(0, NPAGES - 1);
    if (!leaf) begin
      if (r < 86) begin
        v[63:10] = pg + {22'd0, k};
      end else if (r < 93) begin
        v[63:10] = pg + {22'd0, NPAGES};
      end else if (r < 96) begin
        v[63:10] = pg - 54'd1;
      end
    end
    v[0] = ($urandom_range(0, 99) < 90);
    return v;
  endfunction

  // Queue a translation, first filling any table word the walk would read
  function automatic void queue_walk(logic [PPN_W-1:0] root, logic [VA_W-1:0] va);
    walk_item_t        it;
    logic [63:0]       pg;
    logic [63:0]       off;
    logic [63:0]       ent;
    logic [WIDX_W-1:0] w;
    bit                stop;
    pg   = {20'd0, root};
    stop = 1'b0;
    for (int lvl = 0; lvl < 3; lvl++) begin
      if (!stop) begin
        off = pg - {20'd0, plan_base};
        if (pg < {20'd0, plan_base} || off >= {32'd0, NPAGES}) begin
          stop = 1'b1;
        end else begin
          w = {off[PG_W-1:0], va[38-9*lvl -: IDX_W]};
          if (!plan_written[w]) queue_write(w, make_entry(lvl == 2));
          ent = plan_mem[w];
          if (!ent[0]) stop = 1'b1;
          else pg = {10'd0, ent[63:10]};
        end
      end
    end
    it      = rand_fields();
    it.act  = ACT_TRANSLATE;
    it.root = root;
    it.va   = va;
    pending_items.push_back(it);
    plan_count++;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      err_cnt++;
    end
  endfunction

  // Driver: presents queued items, predicts each one on its transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= ACT_WRITE;
    end else begin
      if (s_tvalid && s_tready) expected_xlat.push_back(walk_translate(drv_item));
      if (!s_tvalid || s_tready) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          drv_item = pending_items.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {1'b0, drv_item.va, drv_item.root, drv_item.wval, drv_item.widx};
          s_tuser  <= drv_item.act;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure, checks each result transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_xlat.size() == 0) begin
          $error("result transfer with no item outstanding");
          err_cnt++;
        end else begin
          want_res = expected_xlat.pop_front();
          check_field("status", {62'd0, want_res.status}, {62'd0, m_tuser});
          check_field("hit", {63'd0, want_res.hit}, {63'd0, m_tdata[0]});
          check_field("phys_addr", {8'd0, want_res.pa}, {8'd0, m_tdata[56:1]});
          check_field("prot_bits", {54'd0, want_res.prot}, {54'd0, m_tdata[66:57]});
          check_field("cow_flag", {63'd0, want_res.cow}, {63'd0, m_tdata[67]});
        end
      end
      m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Stimulus: one phase per base page setting
  initial begin
    logic [PPN_W-1:0] phase_base;
    logic [PPN_W-1:0] root;
    logic [PPN_W-1:0] room;
    logic [VA_W-1:0]  va;
    logic [63:0]      rv;
    logic [31:0]      k;
    int unsigned      start;
    int unsigned      r;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      tx_idle_pct = (ph < 2) ? 28 : (ph < 4) ? 68 : 0;
      rx_idle_pct = (ph < 2) ? 68 : (ph < 4) ? 28 : 0;
      rv = rnd64();
      k  = $urandom_range(2, 5);
      case (ph)
        0:       phase_base = '0;
        1:       phase_base = PPN_MAX;
        3:       phase_base = 44'd1;
        4:       phase_base = {12'd0, k};
        default: phase_base = rv[43:0];
      endcase

      // Base page load while nothing is in flight
      @(posedge clk_i);
      cfg_we    <= 1'b1;
      cfg_wdata <= phase_base;
      @(posedge clk_i);
      cfg_we    <= 1'b0;
      pt_base   = phase_base;
      plan_base = phase_base;

      start = plan_count;
      if (ph == 0) begin
        // Directed paths with base page zero
        queue_write(12'd0, 64'h401);
        queue_write(12'd512, 64'h801);
        queue_write(12'd1024, '1);
        queue_walk(44'd0, 39'h0);                    // full walk, leaf all ones
        queue_write(12'd1025, 64'hABCD_0000_1234_50CF);
        queue_walk(44'd0, 39'h1FFF);                 // leaf without copy-on-write
        queue_write(12'd4095, 64'h0);
        queue_walk(44'd7, '1);                       // invalid top entry
        queue_write(12'd1, 64'h2001);
        queue_walk(44'd0, 39'h4000_0000);            // next page just past store
        queue_write(12'd514, 64'hC01);
        queue_write(12'd1539, 64'hFFFF_FFFF_FFFF_FFFE);
        queue_walk(44'd0, 39'h40_3000);              // invalid leaf
        queue_write(12'd517, 64'hFFFF_FFFF_FFFF_FC00);
        queue_walk(44'd0, 39'hA0_0000);              // invalid middle entry
        queue_walk(44'd8, 39'h0);                    // root past store
        queue_walk(PPN_MAX, '1);                     // root at top of range
        queue_write(12'd4095, '1);
        queue_walk(44'd7, '1);                       // next page far out of range
        queue_write(12'd2, 64'h400);
        queue_walk(44'd0, 39'h8000_0000);            // valid bit clear, page set
        queue_walk(44'd0, 39'h0);
      end

      // Random part: mostly walks through built paths, some noise writes
      while (plan_count - start < PHASE_ITEMS) begin
        rv = rnd64();
        r  = $urandom_range(0, 99);
        if (r < 8) begin
          queue_write(rv[11:0], rnd64());
        end else begin
          r    = $urandom_range(0, 99);
          room = PPN_MAX - plan_base;
          k    = $urandom_range(0, NPAGES - 1);
          if ({32'd0, k} > {20'd0, room}) k = room[31:0];
          if (r < 90) root = plan_base + {12'd0, k};
          else if (r < 96) root = rv[43:0];
          else root = plan_base + {12'd0, NPAGES};
          va = rv[63:25];
          for (int j = 0; j < 3; j++) begin
            if ($urandom_range(0, 99) < 60) begin
              k = $urandom_range(0, 3);
              va[38-9*j -: IDX_W] = k[IDX_W-1:0];
            end
          end
          queue_walk(root, va);
        end
      end

      // Drain before the next base page load
      while (pending_items.size() != 0 || s_tvalid || expected_xlat.size() != 0)
        @(posedge clk_i);
      repeat (DRAIN_CYCLES) @(posedge clk_i);
    end

    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
